FILE: hw/rtl/hhft_pkg.sv
// hhft_pkg: types and constants shared by the http header field tokenizer
// no dependencies
`timescale 1ns / 1ps

package hhft_pkg;

  localparam int unsigned BYTE_W = 8;
  localparam int unsigned KIND_W = 3;
  localparam int unsigned IDX_W  = 10;
  localparam int unsigned POS_W  = 25;
  localparam int unsigned HC_W   = 11;
  localparam int unsigned CFG_W  = 25;

  localparam int unsigned HDR_LIMIT_MAX = 1024;

  localparam logic [HC_W-1:0]  MAX_HEADERS_RST   = 11'd1000;
  localparam logic [POS_W-1:0] MAX_FIELD_LEN_RST = 25'd20000000;

  localparam logic [BYTE_W-1:0] CH_LF    = 8'h0A;
  localparam logic [BYTE_W-1:0] CH_CR    = 8'h0D;
  localparam logic [BYTE_W-1:0] CH_COLON = 8'h3A;

  localparam logic CFG_MAX_HEADERS   = 1'b0;
  localparam logic CFG_MAX_FIELD_LEN = 1'b1;

  typedef enum logic [2:0] {
    PH_SKIP_LINE  = 3'd0,
    PH_LINE_START = 3'd1,
    PH_NAME       = 3'd2,
    PH_SKIP_SPACE = 3'd3,
    PH_VALUE      = 3'd4,
    PH_SKIP_LF    = 3'd5,
    PH_DONE       = 3'd6,
    PH_ERROR      = 3'd7
  } phase_t;

  typedef enum logic [KIND_W-1:0] {
    K_NAME      = 3'd0,
    K_VALUE     = 3'd1,
    K_NAME_END  = 3'd2,
    K_VALUE_END = 3'd3,
    K_DONE      = 3'd4,
    K_TOO_MANY  = 3'd5,
    K_TOO_LONG  = 3'd6
  } kind_t;

  typedef struct packed {
    logic [BYTE_W-1:0] data;
    logic              start;
  } item_t;

  typedef struct packed {
    logic [BYTE_W-1:0] data;
    kind_t             kind;
    logic [IDX_W-1:0]  idx;
    logic [POS_W-1:0]  pos;
  } result_t;

endpackage

FILE: hw/rtl/hhft_in_stage.sv
// hhft_in_stage: input register of the tokenizer
// depends on hhft_pkg
`timescale 1ns / 1ps

module hhft_in_stage
  import hhft_pkg::*;
(
  input  logic  clk,
  input  logic  rst_n,
  input  logic  in_valid,
  output logic  in_stall,
  input  item_t in_item,
  input  logic  take,
  output logic  item_valid,
  output item_t item
);

  logic  valid_r, valid_nxt;
  item_t item_r;

  assign in_stall  = valid_r && !take;
  assign valid_nxt = in_stall ? valid_r : in_valid;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall && in_valid) begin
      item_r <= in_item;
    end
  end

  assign item_valid = valid_r;
  assign item       = item_r;

endmodule

FILE: hw/rtl/hhft_parser.sv
// hhft_parser: parse state, limit registers and per-item result logic
// depends on hhft_pkg
`timescale 1ns / 1ps

module hhft_parser
  import hhft_pkg::*;
#(
  parameter int unsigned MAX_HEADERS_LIMIT = 1024
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             cfg_we,
  input  logic             cfg_index,
  input  logic [CFG_W-1:0] cfg_data,
  input  logic             take,
  input  item_t            item,
  output logic             res_valid,
  output result_t          res
);

  localparam int unsigned CAP_INT =
    (MAX_HEADERS_LIMIT < HDR_LIMIT_MAX) ? MAX_HEADERS_LIMIT : HDR_LIMIT_MAX;
  localparam logic [HC_W-1:0] HDR_CAP = HC_W'(CAP_INT);

  logic [HC_W-1:0]  max_headers_r;
  logic [POS_W-1:0] max_field_len_r;
  phase_t           phase_r, phase_nxt;
  logic [HC_W-1:0]  hcount_r, hcount_nxt;
  logic [POS_W-1:0] fpos_r, fpos_nxt;

  phase_t           ph;
  logic [HC_W-1:0]  hc;
  logic [POS_W-1:0] fp;
  logic [HC_W-1:0]  hdr_limit;
  logic             too_long;
  logic [BYTE_W-1:0] b;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_headers_r   <= MAX_HEADERS_RST;
      max_field_len_r <= MAX_FIELD_LEN_RST;
    end else if (cfg_we) begin
      if (cfg_index == CFG_MAX_HEADERS) begin
        max_headers_r <= cfg_data[HC_W-1:0];
      end else begin
        max_field_len_r <= cfg_data[POS_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= PH_SKIP_LINE;
      hcount_r <= '0;
      fpos_r   <= '0;
    end else if (take) begin
      phase_r  <= phase_nxt;
      hcount_r <= hcount_nxt;
      fpos_r   <= fpos_nxt;
    end
  end

  assign b         = item.data;
  assign ph        = item.start ? PH_SKIP_LINE : phase_r;
  assign hc        = item.start ? '0 : hcount_r;
  assign hdr_limit = (max_headers_r > HDR_CAP) ? HDR_CAP : max_headers_r;

  always_comb begin
    phase_nxt  = ph;
    hcount_nxt = hc;
    fpos_nxt   = item.start ? '0 : fpos_r;
    fp         = fpos_nxt;
    res_valid  = 1'b0;
    res.data   = '0;
    res.kind   = K_NAME;
    res.idx    = hc[IDX_W-1:0];
    res.pos    = '0;
    too_long   = 1'b0;
    case (ph)
      PH_SKIP_LINE: begin
        if (b == CH_LF) begin
          phase_nxt = PH_LINE_START;
        end
      end
      PH_LINE_START, PH_NAME: begin
        if (ph == PH_LINE_START) begin
          fp = '0;
        end
        res_valid = 1'b1;
        if (ph == PH_LINE_START && b == CH_CR) begin
          phase_nxt = PH_DONE;
          res.kind  = K_DONE;
          res.idx   = '0;
        end else if (ph == PH_LINE_START && hc >= hdr_limit) begin
          phase_nxt = PH_ERROR;
          res.kind  = K_TOO_MANY;
          res.idx   = '0;
        end else if (b == CH_COLON) begin
          phase_nxt = PH_SKIP_SPACE;
          fpos_nxt  = '0;
          res.kind  = K_NAME_END;
          res.pos   = fp;
        end else begin
          too_long  = fp >= max_field_len_r;
          res.pos   = fp;
          if (too_long) begin
            phase_nxt = PH_ERROR;
            fpos_nxt  = fp;
            res.kind  = K_TOO_LONG;
          end else begin
            phase_nxt = PH_NAME;
            fpos_nxt  = fp + 1'b1;
            res.kind  = K_NAME;
            res.data  = b;
          end
        end
      end
      PH_SKIP_SPACE: begin
        phase_nxt = PH_VALUE;
      end
      PH_VALUE: begin
        res_valid = 1'b1;
        res.pos   = fp;
        if (b == CH_CR) begin
          phase_nxt  = PH_SKIP_LF;
          fpos_nxt   = '0;
          hcount_nxt = hc + 1'b1;
          res.kind   = K_VALUE_END;
        end else begin
          too_long = fp >= max_field_len_r;
          if (too_long) begin
            phase_nxt = PH_ERROR;
            res.kind  = K_TOO_LONG;
          end else begin
            fpos_nxt = fp + 1'b1;
            res.kind = K_VALUE;
            res.data = b;
          end
        end
      end
      PH_SKIP_LF: begin
        phase_nxt = PH_LINE_START;
      end
      default: begin
        phase_nxt = ph;
      end
    endcase
  end

endmodule

FILE: hw/rtl/hhft_out_stage.sv
// hhft_out_stage: result register with stall handling
// depends on hhft_pkg
`timescale 1ns / 1ps

module hhft_out_stage
  import hhft_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  logic    item_valid,
  input  logic    res_valid,
  input  result_t res,
  output logic    take,
  output logic    out_valid,
  input  logic    out_stall,
  output result_t out_res
);

  logic    valid_r, valid_nxt;
  result_t res_r;
  logic    load;

  assign take      = item_valid && (!valid_r || !out_stall);
  assign load      = take && res_valid;
  assign valid_nxt = load ? 1'b1 : (out_stall ? valid_r : 1'b0);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      res_r <= res;
    end
  end

  assign out_valid = valid_r;
  assign out_res   = res_r;

endmodule

FILE: hw/rtl/http_header_field_tokenizer.sv
// a result passes through the input register and then the result register before it is on the out_ ports
// throughput: one item per cycle unless out_stall holds a result; parse state updates in one pass per byte
// an item that causes no result only advances the parse state
// in_stall rises only while a result is held under out_stall
// reset (rst_n low, synchronous): parse state cleared, limits back to 1000 and 20000000
// depends on hhft_pkg, hhft_in_stage, hhft_parser, hhft_out_stage
`timescale 1ns / 1ps

module http_header_field_tokenizer
  import hhft_pkg::*;
#(
  parameter int unsigned MAX_HEADERS_LIMIT = 1024
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_we,
  input  logic              cfg_index,
  input  logic [CFG_W-1:0]  cfg_data,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [BYTE_W-1:0] in_byte,
  input  logic              in_message_start,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [BYTE_W-1:0] out_byte,
  output logic [KIND_W-1:0] out_kind,
  output logic [IDX_W-1:0]  out_header_index,
  output logic [POS_W-1:0]  out_byte_position
);

  item_t   in_item;
  item_t   item;
  logic    item_valid;
  logic    take;
  logic    res_valid;
  result_t res;
  result_t out_res;

  assign in_item.data  = in_byte;
  assign in_item.start = in_message_start;

  hhft_in_stage u_in (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_item    (in_item),
    .take       (take),
    .item_valid (item_valid),
    .item       (item)
  );

  hhft_parser #(
    .MAX_HEADERS_LIMIT (MAX_HEADERS_LIMIT)
  ) u_parser (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .take      (take),
    .item      (item),
    .res_valid (res_valid),
    .res       (res)
  );

  hhft_out_stage u_out (
    .clk        (clk),
    .rst_n      (rst_n),
    .item_valid (item_valid),
    .res_valid  (res_valid),
    .res        (res),
    .take       (take),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_res    (out_res)
  );

  assign out_byte          = out_res.data;
  assign out_kind          = out_res.kind;
  assign out_header_index  = out_res.idx;
  assign out_byte_position = out_res.pos;

endmodule

FILE: hw/rtl/hhft_checker.sv
// hhft_checker: port-level assertions for the tokenizer, bound to the top level
// depends on hhft_pkg and http_header_field_tokenizer
`timescale 1ns / 1ps

module hhft_checker
  import hhft_pkg::*;
(
  input logic              clk,
  input logic              rst_n,
  input logic              in_stall,
  input logic              out_valid,
  input logic              out_stall,
  input logic [BYTE_W-1:0] out_byte,
  input logic [KIND_W-1:0] out_kind,
  input logic [IDX_W-1:0]  out_header_index,
  input logic [POS_W-1:0]  out_byte_position
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_byte) && $stable(out_kind)
      && $stable(out_header_index) && $stable(out_byte_position))
    else $error("stalled item changed");

  a_no_stall_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> !in_stall)
    else $error("input stalled with empty result register");

  a_marker_byte_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_kind != K_NAME && out_kind != K_VALUE |-> out_byte == '0)
    else $error("marker item carries a byte");

  a_done_fields_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_kind == K_DONE || out_kind == K_TOO_MANY)
      |-> out_header_index == '0 && out_byte_position == '0)
    else $error("done or header limit item with index or position");

endmodule

bind http_header_field_tokenizer hhft_checker u_hhft_checker (
  .clk               (clk),
  .rst_n             (rst_n),
  .in_stall          (in_stall),
  .out_valid         (out_valid),
  .out_stall         (out_stall),
  .out_byte          (out_byte),
  .out_kind          (out_kind),
  .out_header_index  (out_header_index),
  .out_byte_position (out_byte_position)
);

FILE: tb/sv/testbench.sv
// testbench: self-checking bench for the http header field tokenizer, random and directed requests
// a scoreboard class predicts every name, value and marker item; depends on hhft_pkg and the rtl
`timescale 1ns / 1ps

module testbench;
  import hhft_pkg::*;

  localparam int unsigned HEADER_CAP    = 1024;
  localparam int unsigned MAX_FIELD_TOP = 33554431;
  localparam int unsigned LONG_HOLD     = 300;
  localparam int unsigned QUIET_LIMIT   = 2000;
  localparam logic [BYTE_W-1:0] SPACE_BYTE = 8'h20;

  class header_token_book;
    result_t pending[$];
    phase_t phase;
    logic [HC_W-1:0] lines_done;
    logic [POS_W-1:0] fpos;
    logic [HC_W-1:0] lim_headers;
    logic [POS_W-1:0] lim_field;
    int unsigned mismatches, checked, too_many, too_long, blocks_done;

    function new();
      lim_headers = MAX_HEADERS_RST;
      lim_field = MAX_FIELD_LEN_RST;
      phase = PH_SKIP_LINE;
      lines_done = '0;
      fpos = '0;
    endfunction

    function void set_limit(logic which, logic [CFG_W-1:0] value);
      if (which == CFG_MAX_HEADERS) begin
        lim_headers = value[HC_W-1:0];
      end else begin
        lim_field = value[POS_W-1:0];
      end
    endfunction

    function result_t token(logic [BYTE_W-1:0] b, kind_t k, logic [IDX_W-1:0] idx,
                            logic [POS_W-1:0] pos);
      result_t r;
      r.data = b;
      r.kind = k;
      r.idx = idx;
      r.pos = pos;
      return r;
    endfunction

    function result_t field_byte(logic [BYTE_W-1:0] b, kind_t k);
      logic [POS_W-1:0] pos;
      pos = fpos;
      if (pos >= lim_field) begin
        phase = PH_ERROR;
        return token('0, K_TOO_LONG, lines_done[IDX_W-1:0], pos);
      end
      fpos = pos + 1'b1;
      return token(b, k, lines_done[IDX_W-1:0], pos);
    endfunction

    function result_t name_byte(logic [BYTE_W-1:0] b);
      logic [POS_W-1:0] len;
      if (b == CH_COLON) begin
        len = fpos;
        fpos = '0;
        phase = PH_SKIP_SPACE;
        return token('0, K_NAME_END, lines_done[IDX_W-1:0], len);
      end
      phase = PH_NAME;
      return field_byte(b, K_NAME);
    endfunction

    // advance the parse state by one accepted item and queue its token, if any
    function void take_byte(logic [BYTE_W-1:0] b, logic start);
      result_t r;
      bit have;
      int unsigned cap;
      have = 1'b0;
      cap = (lim_headers > HEADER_CAP) ? HEADER_CAP : lim_headers;
      if (start) begin
        phase = PH_SKIP_LINE;
        lines_done = '0;
        fpos = '0;
      end
      case (phase)
        PH_SKIP_LINE: begin
          if (b == CH_LF) phase = PH_LINE_START;
        end
        PH_LINE_START: begin
          have = 1'b1;
          if (b == CH_CR) begin
            phase = PH_DONE;
            r = token('0, K_DONE, '0, '0);
          end else if (lines_done >= cap) begin
            phase = PH_ERROR;
            r = token('0, K_TOO_MANY, '0, '0);
          end else begin
            fpos = '0;
            r = name_byte(b);
          end
        end
        PH_NAME: begin
          have = 1'b1;
          r = name_byte(b);
        end
        PH_SKIP_SPACE: phase = PH_VALUE;
        PH_VALUE: begin
          have = 1'b1;
          if (b == CH_CR) begin
            r = token('0, K_VALUE_END, lines_done[IDX_W-1:0], fpos);
            fpos = '0;
            lines_done = lines_done + 1'b1;
            phase = PH_SKIP_LF;
          end else begin
            r = field_byte(b, K_VALUE);
          end
        end
        PH_SKIP_LF: phase = PH_LINE_START;
        default: ;
      endcase
      if (have) pending.push_back(r);
    endfunction

    function void note_miss(string msg);
      mismatches++;
      if (mismatches <= 10) $display("%s", msg);
    endfunction

    function void match_token(logic [BYTE_W-1:0] b, logic [KIND_W-1:0] k,
                              logic [IDX_W-1:0] idx, logic [POS_W-1:0] pos);
      result_t want;
      if (pending.size() == 0) begin
        note_miss($sformatf("unexpected item: byte %02h kind %0d index %0d position %0d",
                            b, k, idx, pos));
        return;
      end
      want = pending.pop_front();
      checked++;
      case (want.kind)
        K_TOO_MANY: too_many++;
        K_TOO_LONG: too_long++;
        K_DONE:     blocks_done++;
        default: ;
      endcase
      if (b !== want.data || k !== want.kind || idx !== want.idx || pos !== want.pos) begin
        note_miss($sformatf({"mismatch: expected byte %02h kind %0d index %0d position %0d,",
                             " got byte %02h kind %0d index %0d position %0d"},
                            want.data, want.kind, want.idx, want.pos, b, k, idx, pos));
      end
    endfunction
  endclass

  logic              clk;
  logic              rst_n;
  logic              cfg_we;
  logic              cfg_index;
  logic [CFG_W-1:0]  cfg_data;
  logic              in_valid;
  logic              in_stall;
  logic [BYTE_W-1:0] in_byte;
  logic              in_message_start;
  logic              out_valid;
  logic              out_stall;
  logic [BYTE_W-1:0] out_byte;
  logic [KIND_W-1:0] out_kind;
  logic [IDX_W-1:0]  out_header_index;
  logic [POS_W-1:0]  out_byte_position;

  header_token_book book;
  int unsigned idle_pct;
  bit long_hold;
  int unsigned quiet_cycles = 0;
  int unsigned bytes_sent = 0;

  http_header_field_tokenizer #(
    .MAX_HEADERS_LIMIT(HEADER_CAP)
  ) dut (
    .clk(clk),
    .rst_n(rst_n),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_byte(in_byte),
    .in_message_start(in_message_start),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_byte(out_byte),
    .out_kind(out_kind),
    .out_header_index(out_header_index),
    .out_byte_position(out_byte_position)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && !in_stall) book.take_byte(in_byte, in_message_start);
      if (out_valid && !out_stall) begin
        book.match_token(out_byte, out_kind, out_header_index, out_byte_position);
      end
      quiet_cycles <= ((in_valid && !in_stall) || (out_valid && !out_stall)) ? 0
                                                                              : quiet_cycles + 1;
    end
  end

  // result side: random stall bursts, plus one long hold-off on request
  initial begin
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (long_hold) begin
        out_stall <= 1'b1;
        repeat (LONG_HOLD) @(negedge clk);
        long_hold = 1'b0;
        out_stall <= 1'b0;
      end else if (idle_pct != 0 && $urandom_range(1, 100) <= idle_pct) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 16)) @(negedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  initial begin
    wait (quiet_cycles >= QUIET_LIMIT);
    $display("watchdog: no handshake for %0d cycles", QUIET_LIMIT);
    $display("TB_ERROR");
    $finish;
  end

  function automatic logic [BYTE_W-1:0] pick_byte_except(logic [BYTE_W-1:0] a,
                                                         logic [BYTE_W-1:0] b);
    logic [BYTE_W-1:0] v;
    do v = 8'($urandom); while (v == a || v == b);
    return v;
  endfunction

  task automatic send_byte(input logic [BYTE_W-1:0] b, input logic start);
    int unsigned gap;
    if (idle_pct != 0 && $urandom_range(1, 100) <= idle_pct) begin
      gap = $urandom_range(1, 16);
      @(negedge clk);
      in_valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_valid <= 1'b1;
    in_byte <= b;
    in_message_start <= start;
    @(posedge clk);
    while (in_stall !== 1'b0) @(posedge clk);
    bytes_sent++;
  endtask

  // idle the input and wait for every expected item plus the pipeline depth
  task automatic settle();
    @(negedge clk);
    in_valid <= 1'b0;
    while (book.pending.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_limit(input logic which, input int unsigned value);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= which;
    cfg_data <= value[CFG_W-1:0];
    book.set_limit(which, value[CFG_W-1:0]);
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic send_request(input int unsigned hdrs, input int unsigned name_max,
                              input int unsigned value_max, input bit cut);
    logic [BYTE_W-1:0] q[$];
    int unsigned n;
    int unsigned keep;
    repeat ($urandom_range(0, 8)) q.push_back(pick_byte_except(CH_LF, CH_LF));
    q.push_back(CH_LF);
    repeat (hdrs) begin
      n = $urandom_range(0, name_max);
      for (int unsigned i = 0; i < n; i++) begin
        q.push_back(i == 0 ? pick_byte_except(CH_CR, CH_COLON)
                           : pick_byte_except(CH_COLON, CH_COLON));
      end
      q.push_back(CH_COLON);
      q.push_back($urandom_range(0, 3) == 0 ? 8'($urandom) : SPACE_BYTE);
      repeat ($urandom_range(0, value_max)) q.push_back(pick_byte_except(CH_CR, CH_CR));
      q.push_back(CH_CR);
      q.push_back($urandom_range(0, 3) == 0 ? 8'($urandom) : CH_LF);
    end
    q.push_back(CH_CR);
    repeat ($urandom_range(0, 2)) q.push_back(8'($urandom));
    keep = cut ? $urandom_range(1, q.size()) : q.size();
    for (int unsigned i = 0; i < keep; i++) send_byte(q[i], i == 0);
  endtask

  task automatic send_noise();
    repeat ($urandom_range(1, 12)) send_byte(8'($urandom), $urandom_range(0, 7) == 0);
  endtask

  initial begin
    logic [BYTE_W:0] opening[$];
    int unsigned random_from;
    opening = '{
      {1'b1, 8'h47}, {1'b0, CH_LF},
      {1'b0, 8'hFF}, {1'b0, 8'h00}, {1'b0, CH_CR}, {1'b0, CH_COLON}, {1'b0, SPACE_BYTE},
      {1'b0, 8'h76}, {1'b0, CH_LF}, {1'b0, 8'hFF}, {1'b0, CH_CR}, {1'b0, CH_LF},
      {1'b0, CH_COLON}, {1'b0, 8'h78}, {1'b0, CH_CR}, {1'b0, 8'h51},
      {1'b0, CH_CR}, {1'b0, 8'h7A},
      {1'b1, CH_LF}, {1'b0, 8'h6B}, {1'b0, CH_COLON}, {1'b0, SPACE_BYTE}, {1'b0, CH_CR},
      {1'b0, CH_LF}, {1'b0, CH_CR}
    };
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_index = CFG_MAX_HEADERS;
    cfg_data = '0;
    in_valid = 1'b0;
    in_byte = '0;
    in_message_start = 1'b0;
    idle_pct = 10;
    long_hold = 1'b0;
    book = new();
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // reset limits: byte extremes, cr and lf inside fields, empty name and value, odd skip bytes
    foreach (opening[i]) send_byte(opening[i][BYTE_W-1:0], opening[i][BYTE_W]);
    settle();

    // zero limits, then only the field limit at zero, then both limits at one
    write_limit(CFG_MAX_HEADERS, 0);
    write_limit(CFG_MAX_FIELD_LEN, 0);
    repeat (2) send_request(2, 3, 3, 1'b0);
    settle();
    write_limit(CFG_MAX_HEADERS, 3);
    repeat (3) send_request(3, 2, 2, 1'b0);
    settle();
    write_limit(CFG_MAX_HEADERS, 1);
    write_limit(CFG_MAX_FIELD_LEN, 1);
    repeat (3) send_request(2, 2, 2, 1'b0);
    settle();

    // result side held off while requests keep coming
    write_limit(CFG_MAX_HEADERS, HEADER_CAP);
    write_limit(CFG_MAX_FIELD_LEN, MAX_FIELD_TOP);
    long_hold = 1'b1;
    repeat (4) send_request(4, 10, 10, 1'b0);

    random_from = bytes_sent;
    while (bytes_sent - random_from < 500) begin
      settle();
      case ($urandom_range(0, 2))
        0: idle_pct = 0;
        1: idle_pct = 5;
        default: idle_pct = 25;
      endcase
      case ($urandom_range(0, 3))
        0: begin
          write_limit(CFG_MAX_HEADERS, $urandom_range(1, 6));
          write_limit(CFG_MAX_FIELD_LEN, $urandom_range(1, 10));
        end
        1: begin
          write_limit(CFG_MAX_HEADERS, $urandom_range(1, HEADER_CAP));
          write_limit(CFG_MAX_FIELD_LEN, $urandom_range(1, MAX_FIELD_TOP));
        end
        2: begin
          write_limit(CFG_MAX_HEADERS, $urandom_range(0, 2047));
          write_limit(CFG_MAX_FIELD_LEN, $urandom_range(0, 40));
        end
        default: begin
          write_limit(CFG_MAX_HEADERS, MAX_HEADERS_RST);
          write_limit(CFG_MAX_FIELD_LEN, MAX_FIELD_LEN_RST);
        end
      endcase
      repeat (3) begin
        if ($urandom_range(0, 4) == 0) begin
          send_noise();
        end else begin
          send_request($urandom_range(0, 6), 10, 12, $urandom_range(0, 9) == 0);
        end
      end
    end

    // closing stretch at full rate
    settle();
    idle_pct = 0;
    write_limit(CFG_MAX_HEADERS, 4);
    write_limit(CFG_MAX_FIELD_LEN, 9);
    repeat (6) send_request($urandom_range(0, 6), 10, 12, 1'b0);
    settle();

    $display("run covered %0d request bytes and %0d checked items: %0d header blocks ended,",
             bytes_sent, book.checked, book.blocks_done);
    $display("%0d header-count errors, %0d field-length errors, %0d mismatches",
             book.too_many, book.too_long, book.mismatches + book.pending.size());
    if (book.mismatches == 0 && book.pending.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

FILE: files.f
hw/rtl/hhft_pkg.sv
hw/rtl/hhft_in_stage.sv
hw/rtl/hhft_parser.sv
hw/rtl/hhft_out_stage.sv
hw/rtl/http_header_field_tokenizer.sv
hw/rtl/hhft_checker.sv
tb/sv/testbench.sv
